// ===== sv/sha_pkg.sv =====
// SHA-256 stream hasher package: round constants, initial vector, queue types.
// No dependencies.
package sha_pkg;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_item;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_OUT
  } core_state_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ===== sv/sha_queue.sv =====
// Request queue between the input front and the compression core.
// Depends on sha_pkg.
module sha_queue #(
  parameter int Depth = sha_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  sha_pkg::req_t wr_data,
  output logic          rd_valid,
  input  logic          rd_take,
  output sha_pkg::req_t rd_data
);
  import sha_pkg::*;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  req_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign wr_stall = (cnt_r == (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 1'b1) else $error("pop count");
  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("push count");
endmodule

// ===== sv/sha_core.sv =====
// Block buffer, padding sequencer, one-round-per-cycle SHA-256 compression and output.
// Depends on sha_pkg.
module sha_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          double_hash,
  input  logic          rq_valid,
  output logic          rq_take,
  input  sha_pkg::req_t rq_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   out_digest_word,
  output logic [2:0]    out_word_index,
  output logic          out_last_word
);
  import sha_pkg::*;

  core_state_t st_r, st_nxt;
  logic [31:0] blk_r [16];
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [60:0] cnt_r;
  logic [5:0]  rnd_r;
  logic [3:0]  ld_r;
  logic        fin_r;    // running padding of current message
  logic        sec_r;    // second pass of double hash
  logic        dbl_r;
  logic        lenblk_r; // current padding block holds length
  logic [2:0]  oidx_r;
  logic [5:0]  pos;
  logic [63:0] bits;
  logic [31:0] wnew, wcur, t1, t2, a2, a15;

  assign pos  = cnt_r[5:0];
  assign bits = {cnt_r, 3'b000};
  assign rq_take = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

  assign a2  = w_r[4'(rnd_r - 6'd2)];
  assign a15 = w_r[4'(rnd_r - 6'd15)];
  assign wnew = (rotr(a2,17) ^ rotr(a2,19) ^ (a2 >> 10)) + w_r[4'(rnd_r - 6'd7)]
              + (rotr(a15,7) ^ rotr(a15,18) ^ (a15 >> 3)) + w_r[rnd_r[3:0]];
  assign wcur = (rnd_r < 6'd16) ? w_r[rnd_r[3:0]] : wnew;
  assign t1 = v_r[7] + (rotr(v_r[4],6) ^ rotr(v_r[4],11) ^ rotr(v_r[4],25))
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + RK[rnd_r] + wcur;
  assign t2 = (rotr(v_r[0],2) ^ rotr(v_r[0],13) ^ rotr(v_r[0],22))
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (rq_valid) begin
        if (rq_data.has_byte && pos == LAST_POS) st_nxt = S_LOAD;
        else if (rq_data.last_item) st_nxt = S_PAD;
      end
      S_LOAD: if (ld_r == 4'd15) st_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 6'd63) st_nxt = S_ADD;
      S_ADD: begin
        if (fin_r && lenblk_r) st_nxt = (dbl_r && !sec_r) ? S_PAD : S_OUT;
        else if (fin_r) st_nxt = S_LOAD;
        else st_nxt = S_IDLE;
      end
      S_PAD: st_nxt = S_LOAD;
      S_OUT: if (!out_stall && oidx_r == 3'd7) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rnd_r <= '0; ld_r <= '0; fin_r <= 1'b0; sec_r <= 1'b0;
      dbl_r <= 1'b0; lenblk_r <= 1'b0; oidx_r <= '0;
      for (int j = 0; j < 8; j++) h_r[j] <= IV[j];
    end else begin
      case (st_r)
        S_IDLE: if (rq_valid) begin
          if (rq_data.has_byte) cnt_r <= cnt_r + 1'b1;
          if (rq_data.last_item) begin
            fin_r <= 1'b1;
            dbl_r <= double_hash;
          end
        end
        S_LOAD: begin
          ld_r <= ld_r + 1'b1;
          rnd_r <= '0;
          if (ld_r == 4'd15) for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
        end
        S_ROUND: begin
          rnd_r <= rnd_r + 1'b1;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
        end
        S_ADD: begin
          if (fin_r && lenblk_r && dbl_r && !sec_r) begin
            // digest becomes a 32-byte message
            for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
            cnt_r <= 61'd32;
            sec_r <= 1'b1;
          end else if (!(fin_r && lenblk_r)) begin
            for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
          end else begin
            for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
          end
          if (fin_r && !lenblk_r) lenblk_r <= 1'b1;
        end
        S_PAD: begin
          lenblk_r <= (pos < LEN_POS) || sec_r;
          if (sec_r) for (int j = 0; j < 8; j++) h_r[j] <= IV[j];
        end
        S_OUT: if (!out_stall) begin
          oidx_r <= oidx_r + 1'b1;
          if (oidx_r == 3'd7) begin
            for (int j = 0; j < 8; j++) h_r[j] <= IV[j];
            cnt_r <= '0; fin_r <= 1'b0; sec_r <= 1'b0; lenblk_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // block buffer and schedule
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (rq_valid && rq_data.has_byte)
        blk_r[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= rq_data.data_byte;
      S_PAD: begin
        if (sec_r) begin
          for (int j = 0; j < 8; j++) blk_r[j] <= h_r[j];
          blk_r[8] <= {PAD_BYTE, 24'h000000};
          for (int j = 9; j < 14; j++) blk_r[j] <= '0;
          blk_r[14] <= bits[63:32];
          blk_r[15] <= bits[31:0];
        end else begin
          for (int j = 0; j < 64; j++) begin
            if (6'(j) == pos) blk_r[j/4][31-8*(j%4) -: 8] <= PAD_BYTE;
            else if (6'(j) > pos) blk_r[j/4][31-8*(j%4) -: 8] <= 8'h00;
          end
          if (pos < LEN_POS) begin
            blk_r[14] <= bits[63:32];
            blk_r[15] <= bits[31:0];
          end
        end
      end
      S_ADD: if (fin_r && !lenblk_r) begin
        for (int j = 0; j < 14; j++) blk_r[j] <= '0;
        // message ended on a block boundary: pad byte opens the length block
        if (pos == '0) blk_r[0] <= {PAD_BYTE, 24'h000000};
        blk_r[14] <= bits[63:32];
        blk_r[15] <= bits[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_LOAD)
      w_r[ld_r] <= blk_r[ld_r];
    else if (st_r == S_ROUND && rnd_r >= 6'd16)
      w_r[rnd_r[3:0]] <= wnew;
  end

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rq_take |-> !out_valid) else $error("take while emitting");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(oidx_r)) else $error("out hold");
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ROUND && rnd_r == 6'd63 |=> st_r == S_ADD) else $error("round end");
endmodule

// ===== sv/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top: request queue in front of the compression core.
// Depends on sha_pkg, sha_queue, sha_core.
//
//  channel  ports                                      direction
//  in       in_valid in_stall in_data_byte in_has_byte in_last_item   request in
//  out      out_valid out_stall out_digest_word out_word_index out_last_word result
//  cfg      cfg_we cfg_double_hash                      register write
//
// Each byte goes into the block buffer; a full block is loaded into the schedule,
// compressed round by round and added into the hash state. Padding adds the S_PAD state
// and one or two blocks, double mode S_PAD and one block more, then eight digest words
// held by out_stall. The queue keeps taking requests until full while the core compresses.
// Synchronous active-low reset restores the initial vector and a zero count.
module sha256_stream_hasher #(
  parameter int QDepth = sha_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  input  logic        cfg_we,
  input  logic        cfg_double_hash
);
  import sha_pkg::*;
  req_t wr_d, rd_d;
  logic rd_v, rd_t, dbl_r;

  assign wr_d = '{data_byte: in_data_byte, has_byte: in_has_byte, last_item: in_last_item};

  always_ff @(posedge clk) begin
    if (!rst_n) dbl_r <= 1'b0;
    else if (cfg_we) dbl_r <= cfg_double_hash;
  end

  sha_queue #(.Depth(QDepth)) u_q (
    .clk, .rst_n, .wr_valid(in_valid), .wr_stall(in_stall), .wr_data(wr_d),
    .rd_valid(rd_v), .rd_take(rd_t), .rd_data(rd_d));

  sha_core u_core (
    .clk, .rst_n, .double_hash(dbl_r), .rq_valid(rd_v), .rq_take(rd_t),
    .rq_data(rd_d), .out_valid, .out_stall, .out_digest_word, .out_word_index,
    .out_last_word);
endmodule
